// ===== rtl/mmms_pkg.sv =====
// ----------------------------------------------------------------------------
// mmms_pkg
// Shared constants and types for the mean / median / mode statistics unit.
// ----------------------------------------------------------------------------
package mmms_pkg;

    // width of every value field on the ports
    localparam int DATA_W = 16;

    // job queue between the load side and the compute side
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              empty;
        logic [QLVL_W-1:0] level;
    } q_status_t;

endpackage

// ===== rtl/mmms_jobq.sv =====
// ----------------------------------------------------------------------------
// mmms_jobq
// Two-entry queue of closed sets waiting for the compute side.
// ----------------------------------------------------------------------------
module mmms_jobq
    import mmms_pkg::*;
#(
    parameter int W = 36
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output q_status_t    q_stat
);

    logic [W-1:0]      q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0] level_reg, level_next;
    logic              do_push;
    logic              do_pop;

    assign do_push = push && (level_reg != QLVL_W'(QUEUE_DEPTH));
    assign do_pop  = pop && (level_reg != '0);

    assign pop_data     = q_mem[rd_ptr_reg];
    assign q_stat.empty = (level_reg == '0);
    assign q_stat.level = level_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/mmms_front.sv =====
// ----------------------------------------------------------------------------
// mmms_front
// Load side: takes one value per beat while not busy, stores it, keeps count, sum and
// overflow, and queues a job when the last value of a set arrives.
// ----------------------------------------------------------------------------
module mmms_front
    import mmms_pkg::*;
#(
    parameter int MAX_ITEMS  = 256,
    parameter int VALUE_BITS = 16,
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1),
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
    localparam int SUM_W     = VALUE_BITS + CNT_W,
    localparam int JOB_W     = SUM_W + CNT_W + 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DATA_W-1:0]   sample_value,
    input  logic                last_item,
    input  q_status_t           q_stat,
    input  logic                back_active,
    output logic                busy,
    output logic                wr_en,
    output logic [IDX_W:0]      wr_addr,
    output logic [VALUE_BITS-1:0] wr_data,
    output logic                push,
    output logic [JOB_W-1:0]    push_data
);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  ovf_reg, ovf_next;
    logic                  bank_reg, bank_next;
    logic [QLVL_W:0]       outstanding;
    logic                  accept;
    logic                  has_room;
    logic [VALUE_BITS-1:0] v;
    logic [CNT_W-1:0]      cnt_new;
    logic [SUM_W-1:0]      sum_new;
    logic                  ovf_new;

    // each set in the queue or under compute holds one bank of the store
    assign outstanding = {1'b0, q_stat.level} + (QLVL_W + 1)'(back_active);
    assign busy        = (outstanding >= (QLVL_W + 1)'(QUEUE_DEPTH));
    assign accept      = start && !busy;

    assign has_room = (count_reg < CNT_W'(MAX_ITEMS));
    assign v        = VALUE_BITS'(sample_value);
    assign cnt_new  = has_room ? (count_reg + 1'b1) : count_reg;
    assign sum_new  = has_room ? (sum_reg + SUM_W'(v)) : sum_reg;
    assign ovf_new  = ovf_reg | ~has_room;

    assign wr_en     = accept && has_room;
    assign wr_addr   = {bank_reg, count_reg[IDX_W-1:0]};
    assign wr_data   = v;
    assign push      = accept && last_item;
    assign push_data = {bank_reg, cnt_new, sum_new, ovf_new};

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (last_item)
            begin
                // close the set and move to the other bank
                count_next = '0;
                sum_next   = '0;
                ovf_next   = 1'b0;
                bank_next  = ~bank_reg;
            end
            else
            begin
                count_next = cnt_new;
                sum_next   = sum_new;
                ovf_next   = ovf_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

// ===== rtl/mmms_back.sv =====
// ----------------------------------------------------------------------------
// mmms_back
// Compute side: holds the value store, and per queued set runs a bit-serial
// divide for the mean, reads the middle entries for the median and scans all
// pairs for the mode.
// ----------------------------------------------------------------------------
module mmms_back
    import mmms_pkg::*;
#(
    parameter int MAX_ITEMS  = 256,
    parameter int VALUE_BITS = 16,
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1),
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
    localparam int SUM_W     = VALUE_BITS + CNT_W,
    localparam int JOB_W     = SUM_W + CNT_W + 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [IDX_W:0]        wr_addr,
    input  logic [VALUE_BITS-1:0] wr_data,
    input  q_status_t             q_stat,
    output logic                  pop,
    input  logic [JOB_W-1:0]      pop_data,
    output logic                  active,
    output logic                  done,
    output logic [DATA_W-1:0]     mean_value,
    output logic [DATA_W-1:0]     median_value,
    output logic [DATA_W-1:0]     mode_value,
    output logic                  has_mode,
    output logic                  overflowed
);

    localparam int DIVC_W    = $clog2(SUM_W + 1);
    localparam int MEM_DEPTH = 2 * (2 ** IDX_W);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DIV      = 7'b0000010,
        ST_MED_RD   = 7'b0000100,
        ST_MED_CALC = 7'b0001000,
        ST_OUT_RD   = 7'b0010000,
        ST_INNER    = 7'b0100000,
        ST_DONE     = 7'b1000000
    } back_state_t;

    logic [VALUE_BITS-1:0] store_mem [MEM_DEPTH];
    logic [VALUE_BITS-1:0] rd_a_reg, rd_b_reg;
    logic [IDX_W:0]        rd_addr_a, rd_addr_b;

    back_state_t           state_reg, state_next;
    logic                  bank_reg, bank_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [SUM_W-1:0]      quo_reg, quo_next;
    logic [DIVC_W-1:0]     dstep_reg, dstep_next;
    logic [VALUE_BITS-1:0] med_reg, med_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      best_cnt_reg, best_cnt_next;
    logic [VALUE_BITS-1:0] best_val_reg, best_val_next;
    logic                  done_reg, done_next;
    logic [DATA_W-1:0]     mean_out_reg, mean_out_next;
    logic [DATA_W-1:0]     median_out_reg, median_out_next;
    logic [DATA_W-1:0]     mode_out_reg, mode_out_next;
    logic                  has_mode_reg, has_mode_next;
    logic                  ovf_out_reg, ovf_out_next;

    logic                  job_bank;
    logic [CNT_W-1:0]      job_cnt;
    logic [SUM_W-1:0]      job_sum;
    logic                  job_ovf;
    logic [CNT_W:0]        rem_sh;
    logic [CNT_W:0]        rem_diff;
    logic                  ge;
    logic [CNT_W-1:0]      cnt_m1;
    logic [CNT_W-1:0]      lo_pos;
    logic [CNT_W-1:0]      hi_pos;
    logic [VALUE_BITS:0]   pair_sum;
    logic                  eq;
    logic [CNT_W-1:0]      n_inc;
    logic [CNT_W-1:0]      i_inc;
    logic                  found;

    assign {job_bank, job_cnt, job_sum, job_ovf} = pop_data;

    assign pop    = (state_reg == ST_IDLE) && !q_stat.empty;
    assign active = (state_reg != ST_IDLE);

    // restoring divide step: one quotient bit per cycle
    assign rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign ge       = (rem_sh >= {1'b0, cnt_reg});
    assign rem_diff = rem_sh - {1'b0, cnt_reg};

    assign cnt_m1   = cnt_reg - 1'b1;
    assign lo_pos   = cnt_m1 >> 1;
    assign hi_pos   = cnt_reg >> 1;
    assign pair_sum = {1'b0, rd_a_reg} + {1'b0, rd_b_reg};

    assign eq    = (rd_a_reg == rd_b_reg);
    assign n_inc = n_reg + CNT_W'(eq);
    assign i_inc = i_reg + 1'b1;
    assign found = !((cnt_reg > CNT_W'(1)) && (best_cnt_reg == CNT_W'(1)));

    always_comb
    begin
        rd_addr_a = {bank_reg, i_reg[IDX_W-1:0]};
        rd_addr_b = {bank_reg, j_reg[IDX_W-1:0]};
        unique case (state_reg)
            ST_MED_RD:
            begin
                rd_addr_a = {bank_reg, lo_pos[IDX_W-1:0]};
                rd_addr_b = {bank_reg, hi_pos[IDX_W-1:0]};
            end
            ST_OUT_RD:
            begin
                rd_addr_b = {bank_reg, {IDX_W{1'b0}}};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= store_mem[rd_addr_a];
        rd_b_reg <= store_mem[rd_addr_b];
    end

    always_comb
    begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dstep_next      = dstep_reg;
        med_next        = med_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        best_cnt_next   = best_cnt_reg;
        best_val_next   = best_val_reg;
        done_next       = 1'b0;
        mean_out_next   = mean_out_reg;
        median_out_next = median_out_reg;
        mode_out_next   = mode_out_reg;
        has_mode_next   = has_mode_reg;
        ovf_out_next    = ovf_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    bank_next  = job_bank;
                    cnt_next   = job_cnt;
                    ovf_next   = job_ovf;
                    quo_next   = job_sum;
                    rem_next   = '0;
                    dstep_next = DIVC_W'(SUM_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next   = {quo_reg[SUM_W-2:0], ge};
                rem_next   = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                dstep_next = dstep_reg - 1'b1;
                if (dstep_reg == DIVC_W'(1))
                begin
                    state_next = ST_MED_RD;
                end
            end
            ST_MED_RD:
            begin
                state_next = ST_MED_CALC;
            end
            ST_MED_CALC:
            begin
                med_next      = cnt_reg[0] ? rd_b_reg : pair_sum[VALUE_BITS:1];
                i_next        = '0;
                best_cnt_next = '0;
                best_val_next = '0;
                state_next    = ST_OUT_RD;
            end
            ST_OUT_RD:
            begin
                j_next     = CNT_W'(1);
                n_next     = '0;
                state_next = ST_INNER;
            end
            ST_INNER:
            begin
                // compare data of entry j-1 against entry i
                if (j_reg == cnt_reg)
                begin
                    if (n_inc > best_cnt_reg)
                    begin
                        best_cnt_next = n_inc;
                        best_val_next = rd_a_reg;
                    end
                    if (i_inc == cnt_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = ST_OUT_RD;
                    end
                end
                else
                begin
                    n_next = n_inc;
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                done_next       = 1'b1;
                mean_out_next   = DATA_W'(quo_reg[VALUE_BITS-1:0]);
                median_out_next = DATA_W'(med_reg);
                mode_out_next   = found ? DATA_W'(best_val_reg) : '0;
                has_mode_next   = found;
                ovf_out_next    = ovf_reg;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            best_cnt_reg <= '0;
            best_val_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            best_cnt_reg <= best_cnt_next;
            best_val_reg <= best_val_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg       <= bank_next;
        cnt_reg        <= cnt_next;
        ovf_reg        <= ovf_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        dstep_reg      <= dstep_next;
        med_reg        <= med_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        n_reg          <= n_next;
        mean_out_reg   <= mean_out_next;
        median_out_reg <= median_out_next;
        mode_out_reg   <= mode_out_next;
        has_mode_reg   <= has_mode_next;
        ovf_out_reg    <= ovf_out_next;
    end

    assign done         = done_reg;
    assign mean_value   = mean_out_reg;
    assign median_value = median_out_reg;
    assign mode_value   = mode_out_reg;
    assign has_mode     = has_mode_reg;
    assign overflowed   = ovf_out_reg;

endmodule

// ===== rtl/mean_median_mode_stats_unit.sv =====
// Loading: one value per cycle while busy is low; busy rises only while two closed sets are pending.
// Result: per closed set, the bit-serial divider (SUM_W = VALUE_BITS + clog2(MAX_ITEMS+1)
// quotient bits) runs, then the median read and the pairwise mode scan over the single
// two-read-port value store; done then pulses with the mean, median and mode.
// The receiver cannot stall; done is high for a single cycle and the result outputs hold until the next result.
// Reset (rst_n low, asynchronous) empties the queue and starts an empty set.
// ----------------------------------------------------------------------------
// mean_median_mode_stats_unit
// Top level: load side, job queue and compute side of the statistics unit.
// ----------------------------------------------------------------------------
module mean_median_mode_stats_unit
    import mmms_pkg::*;
#(
    parameter int MAX_ITEMS  = 256,
    parameter int VALUE_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [DATA_W-1:0] sample_value,
    input  logic              last_item,
    output logic              done,
    output logic [DATA_W-1:0] mean_value,
    output logic [DATA_W-1:0] median_value,
    output logic [DATA_W-1:0] mode_value,
    output logic              has_mode,
    output logic              overflowed
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int SUM_W = VALUE_BITS + CNT_W;
    localparam int JOB_W = SUM_W + CNT_W + 2;

    logic                  wr_en;
    logic [IDX_W:0]        wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  push;
    logic [JOB_W-1:0]      push_data;
    logic                  pop;
    logic [JOB_W-1:0]      pop_data;
    q_status_t             q_stat;
    logic                  back_active;

    mmms_front #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .sample_value (sample_value),
        .last_item    (last_item),
        .q_stat       (q_stat),
        .back_active  (back_active),
        .busy         (busy),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .push         (push),
        .push_data    (push_data)
    );

    mmms_jobq #(
        .W (JOB_W)
    ) u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    mmms_back #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .q_stat       (q_stat),
        .pop          (pop),
        .pop_data     (pop_data),
        .active       (back_active),
        .done         (done),
        .mean_value   (mean_value),
        .median_value (median_value),
        .mode_value   (mode_value),
        .has_mode     (has_mode),
        .overflowed   (overflowed)
    );

endmodule

// ===== rtl/mmms_checker.sv =====
// ----------------------------------------------------------------------------
// mmms_checker
// Port-level checks on the statistics unit, bound to the top level.
// ----------------------------------------------------------------------------
module mmms_checker
    import mmms_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              last_item,
    input logic              done,
    input logic [DATA_W-1:0] mode_value,
    input logic              has_mode
);

    logic [1:0] pend_reg, pend_next;
    logic       set_closed;

    assign set_closed = start && !busy && last_item;

    // track sets closed but not yet reported
    always_comb
    begin
        pend_next = pend_reg;
        if (set_closed && !done)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (done && !set_closed)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one beat");

    a_done_owed: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pend_reg != 2'd0))
        else $error("result without a closed set");

    a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        ((pend_reg == 2'd2) && !done) |-> busy)
        else $error("input taken while both store banks are held");

    a_no_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !has_mode) |-> (mode_value == '0))
        else $error("mode value nonzero without a mode");

endmodule

bind mean_median_mode_stats_unit mmms_checker u_mmms_checker (.*);
